/* hw/rtl/command_frame_receiver_top_assert.svh */
// Assertion macros for the command frame receiver.
`ifndef COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define CFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("command frame receiver assertion failed");

`define CFR_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("command frame receiver forbidden condition");

`else

`define CFR_ASSERT(lbl, clk, rst, prop)

`define CFR_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* hw/rtl/cfr_pkg.sv */
// Shared constants and types of the command frame receiver.
package cfr_pkg;

  localparam int PAY_LEN = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] HDR_BYTE = 8'hFF;

  localparam logic [3:0] PHASE_HUNT  = 4'd0;
  localparam logic [3:0] PHASE_LAST  = 4'd12;
  localparam logic [3:0] PHASE_CHECK = 4'd13;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_4 = 8'h34;
  localparam logic [7:0] CH_9 = 8'h39;

  typedef struct packed {
    logic ok;
    logic r0_on;
    logic r0_zero;
    logic r0_off;
    logic r1_on;
    logic r1_zero;
    logic r1_off;
    logic r2_off;
    logic cooler_on;
    logic cooler_off;
    logic light_on;
    logic light_off;
  } cmd_t;

endpackage

/* hw/rtl/command_frame_receiver_top.sv */
// Command frame receiver top level.
//
// Input channel: one received byte per word on rx_byte, taken when push is
// high and full is low. Bytes are dropped until a 0xFF header; the next 12
// bytes form the payload and the byte after them is the checksum (sum of the
// payload mod 256). 0xFF inside a frame is plain data.
// Result channel: one word per completed frame on frame_ok, relay_out and
// message_flags, valid while empty is low and taken when pop is high.
// Throughput: one byte per cycle, sustained; full rises only on a checksum
// byte while the two-entry command queue is full.
// The result of a frame is written to the command queue when its checksum
// byte is taken, and moves on to the result register when that is free.
// A stalled result holds in the result register; the command queue then
// fills, and only after that does the front end stall on a checksum.
// Reset clears the frame phase, checksum, relay bits, on-latches, queue and
// result valid flag; the payload store and result data keep what they held.
`include "command_frame_receiver_top_assert.svh"

module command_frame_receiver_top #(
  parameter int QUEUE_DEPTH = cfr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic       frame_ok,
  output logic [3:0] relay_out,
  output logic [5:0] message_flags
);

  cfr_pkg::cmd_t fq_wr_cmd;
  cfr_pkg::cmd_t fq_rd_cmd;
  logic          fq_push;
  logic          fq_pop;
  logic          fq_full;
  logic          fq_empty;

  cfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .fq_push (fq_push),
    .fq_cmd  (fq_wr_cmd),
    .fq_full (fq_full)
  );

  cfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_wr_cmd),
    .rd_en   (fq_pop),
    .rd_data (fq_rd_cmd),
    .full    (fq_full),
    .empty   (fq_empty)
  );

  cfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .fq_empty      (fq_empty),
    .fq_cmd        (fq_rd_cmd),
    .fq_pop        (fq_pop),
    .empty         (empty),
    .pop           (pop),
    .frame_ok      (frame_ok),
    .relay_out     (relay_out),
    .message_flags (message_flags)
  );

  `CFR_ASSERT_NEVER(a_queue_overflow, clk, rst, fq_push && fq_full)
  `CFR_ASSERT(a_bad_frame_no_msg, clk, rst, (!empty && !frame_ok) |-> (message_flags == 6'd0))
  `CFR_ASSERT(a_light_on_relay, clk, rst, (!empty && message_flags[4]) |-> relay_out[3])
  `CFR_ASSERT(a_cooler_off_relay, clk, rst, (!empty && message_flags[3]) |-> !relay_out[2])

endmodule

/* hw/rtl/cfr_fifo.sv */
// Short command queue between the frame front end and the relay back end.
module cfr_fifo #(
  parameter int DEPTH = cfr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  cfr_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output cfr_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfr_pkg::cmd_t        entries [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* hw/rtl/cfr_front.sv */
// Frame front end: header hunt, payload capture, checksum and command decode.
module cfr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          full,
  output logic          fq_push,
  output cfr_pkg::cmd_t fq_cmd,
  input  logic          fq_full
);

  logic [3:0] phase;
  logic [7:0] sum;
  logic [7:0] store [cfr_pkg::PAY_LEN];
  logic       accept;
  logic       in_payload;
  logic [3:0] wr_idx;

  assign full       = (phase == cfr_pkg::PHASE_CHECK) && fq_full;
  assign accept     = push && !full;
  assign in_payload = (phase != cfr_pkg::PHASE_HUNT) && (phase <= cfr_pkg::PHASE_LAST);
  assign wr_idx     = phase - 4'd1;
  assign fq_push    = accept && (phase == cfr_pkg::PHASE_CHECK);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cfr_pkg::PHASE_HUNT;
      sum   <= '0;
    end else if (accept) begin
      if (phase == cfr_pkg::PHASE_HUNT) begin
        if (rx_byte == cfr_pkg::HDR_BYTE) begin
          phase <= 4'd1;
          sum   <= '0;
        end
      end else if (in_payload) begin
        phase <= phase + 4'd1;
        sum   <= sum + rx_byte;
      end else begin
        phase <= cfr_pkg::PHASE_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_payload) begin
      store[wr_idx] <= rx_byte;
    end
  end

  always_comb begin
    fq_cmd.ok         = (rx_byte == sum);
    fq_cmd.r0_on      = (store[0] == cfr_pkg::CH_1);
    fq_cmd.r0_zero    = (store[0] == cfr_pkg::CH_0);
    fq_cmd.r0_off     = (store[1] == cfr_pkg::CH_2);
    fq_cmd.r1_on      = (store[2] == cfr_pkg::CH_3);
    fq_cmd.r1_zero    = (store[2] == cfr_pkg::CH_0);
    fq_cmd.r1_off     = (store[3] == cfr_pkg::CH_4);
    fq_cmd.r2_off     = (store[4] == cfr_pkg::CH_0);
    fq_cmd.cooler_on  = (store[8] == cfr_pkg::CH_9);
    fq_cmd.cooler_off = (store[9] == cfr_pkg::CH_1);
    fq_cmd.light_on   = (store[10] == cfr_pkg::CH_2) && (store[11] == cfr_pkg::CH_0);
    fq_cmd.light_off  = (store[10] == cfr_pkg::CH_0) && (store[11] == cfr_pkg::CH_3);
  end

endmodule

/* hw/rtl/cfr_back.sv */
// Relay back end: applies decoded commands and holds the result word.
module cfr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          fq_empty,
  input  cfr_pkg::cmd_t fq_cmd,
  output logic          fq_pop,
  output logic          empty,
  input  logic          pop,
  output logic          frame_ok,
  output logic [3:0]    relay_out,
  output logic [5:0]    message_flags
);

  logic [3:0] relay;
  logic [1:0] latch;
  logic       out_valid;
  logic [3:0] relay_next;
  logic [1:0] latch_next;
  logic [5:0] msg_next;

  assign empty  = !out_valid;
  assign fq_pop = !fq_empty && (!out_valid || pop);

  always_comb begin
    relay_next = relay;
    latch_next = latch;
    msg_next   = '0;
    if (fq_cmd.ok) begin
      if (fq_cmd.r0_on) begin
        relay_next[0] = 1'b1;
        latch_next[0] = 1'b1;
        msg_next[0]   = 1'b1;
      end else if (fq_cmd.r0_zero && !latch[0]) begin
        relay_next[0] = 1'b0;
      end
      if (fq_cmd.r0_off) begin
        relay_next[0] = 1'b0;
      end
      if (fq_cmd.r1_on) begin
        relay_next[1] = 1'b1;
        latch_next[1] = 1'b1;
        msg_next[1]   = 1'b1;
      end else if (fq_cmd.r1_zero && !latch[1]) begin
        relay_next[1] = 1'b0;
      end
      if (fq_cmd.r1_off) begin
        relay_next[1] = 1'b0;
      end
      if (fq_cmd.r2_off) begin
        relay_next[2] = 1'b0;
      end
      if (fq_cmd.cooler_on) begin
        relay_next[2] = 1'b1;
        msg_next[2]   = 1'b1;
      end
      if (fq_cmd.cooler_off) begin
        relay_next[2] = 1'b0;
        msg_next[3]   = 1'b1;
      end
      if (fq_cmd.light_on) begin
        relay_next[3] = 1'b1;
        msg_next[4]   = 1'b1;
      end
      if (fq_cmd.light_off) begin
        relay_next[3] = 1'b0;
        msg_next[5]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      relay     <= '0;
      latch     <= '0;
    end else if (fq_pop) begin
      out_valid <= 1'b1;
      relay     <= relay_next;
      latch     <= latch_next;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      frame_ok      <= fq_cmd.ok;
      relay_out     <= relay_next;
      message_flags <= msg_next;
    end
  end

endmodule
